// File: hw/rtl/frmc_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared constants for the frame rate meter and its serial arithmetic unit.
// ----------------------------------------------------------------------------
package frmc_pkg;

	localparam logic [17:0] MAX_DELTA_US = 18'd250000;
	localparam logic [20:0] WINDOW_US    = 21'd1000000;
	localparam logic [25:0] MINUTE_US    = 26'd60000000;
	localparam logic [27:0] MASK28       = 28'hFFFFFFF;
	localparam logic [19:0] FRAMES_MAX   = 20'hFFFFF;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [0:0] REG_TARGET = 1'b0;
	localparam logic [0:0] REG_PAUSE  = 1'b1;

	// Dividend width for the serial divider.
	localparam int DW = 50;

endpackage

// File: hw/rtl/frame_rate_meter_with_game_clock.sv
// ----------------------------------------------------------------------------
// Frame rate meter with game clock
// Running tick items update elapsed time, frame count, a windowed frame rate, an
// average rate, a packed hour:minute clock and a sleep suggestion.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one item per frame:
// cmd, raw_dt_us and time_word. The output channel (out_valid, out_stall)
// returns one result item per input item. Configuration is written through
// the APB port: target_rate at address 0, pause_mode at address 4.
// One item is handled at a time. The result item of a set-time item, the
// first tick or a paused tick goes from idle straight to the output state.
// A running tick passes through the update, sleep and rate states, and through
// the average state when it closes a one-second window. The sleep division
// runs only when a sleep is suggested, the rate division only when the window
// closes, and the average division unless the average is still zero. All
// divisions go through one shared serial divider that retires one quotient
// bit per cycle. A new item is accepted after its result item has been taken.
// Reset clears all counters, the clock and the rates, and sets target_rate
// to 60. While the receiver stalls the result is held in the output register
// and no new item is accepted.
// ----------------------------------------------------------------------------
module frame_rate_meter_with_game_clock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [23:0] raw_dt_us,
	input  logic [31:0] time_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [17:0] delta_us,
	output logic [47:0] elapsed_us,
	output logic [31:0] frames_total,
	output logic [27:0] rate_now,
	output logic [27:0] rate_avg,
	output logic        rate_updated,
	output logic [4:0]  clock_hour,
	output logic [5:0]  clock_minute,
	output logic [10:0] minute_of_day,
	output logic [19:0] sleep_us,
	output logic [31:0] clock_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_SLEEP = 3'd2;
	localparam logic [2:0] ST_RATE  = 3'd3;
	localparam logic [2:0] ST_AVG   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;
	localparam logic [2:0] ST_WAIT  = 3'd6;

	logic [2:0]  state_q;
	logic [9:0]  target_q;
	logic        pause_q;
	logic        first_q;
	logic [47:0] elapsed_q;
	logic [31:0] frames_q;
	logic [20:0] win_time_q;
	logic [19:0] win_frames_q;
	logic [27:0] rate_last_q;
	logic [27:0] rate_smooth_q;
	logic [25:0] min_frac_q;
	logic [31:0] clock_q;
	logic [23:0] raw_q;
	logic [17:0] delta_q;
	logic        upd_q;
	logic [19:0] sleep_q;
	logic        wait_div_q;

	logic                    div_start;
	logic [frmc_pkg::DW-1:0] div_dividend;
	logic [31:0]             div_divisor;
	logic                    div_done;
	logic [frmc_pkg::DW-1:0] div_quot;

	logic        accept;
	logic [34:0] load;
	logic [20:0] win_sum;
	logic [26:0] frac_sum;
	logic [5:0]  mn;
	logic [5:0]  mn1;
	logic [4:0]  hr1;
	logic [31:0] avg9;
	logic [19:0] wf_inc;

	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign prdata   = (paddr[2] == frmc_pkg::REG_PAUSE) ? {31'd0, pause_q} : {22'd0, target_q};

	assign load     = 35'(raw_q) * 35'(target_q);
	assign win_sum  = win_time_q + 21'(delta_q);
	assign frac_sum = 27'(min_frac_q) + 27'(delta_q);
	assign wf_inc   = (win_frames_q < frmc_pkg::FRAMES_MAX) ? win_frames_q + 20'd1 : win_frames_q;
	assign mn       = clock_q[5:0];
	assign avg9     = {rate_smooth_q, 3'd0} + 32'(rate_smooth_q) + 32'(rate_last_q);

	always_comb begin
		mn1 = mn + 6'd1;
		hr1 = clock_q[10:6];
		if (mn >= 6'd59) begin
			mn1 = 6'd0;
			hr1 = hr1 + 5'd1;
			if (hr1 >= 5'd24) begin
				hr1 = 5'd0;
			end
		end
	end

	frmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_SLEEP: begin
				div_start    = !wait_div_q;
				div_dividend = frmc_pkg::DW'(35'd1000000 - load);
				div_divisor  = 32'(target_q);
			end
			ST_RATE: begin
				div_start    = !wait_div_q;
				div_dividend = frmc_pkg::DW'({win_frames_q, 8'd0}) * frmc_pkg::DW'(1000000);
				div_divisor  = 32'(win_time_q);
			end
			ST_AVG: begin
				div_start    = !wait_div_q;
				div_dividend = frmc_pkg::DW'(avg9);
				div_divisor  = 32'd10;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			target_q      <= 10'd60;
			pause_q       <= 1'b0;
			first_q       <= 1'b1;
			elapsed_q     <= '0;
			frames_q      <= '0;
			win_time_q    <= '0;
			win_frames_q  <= '0;
			rate_last_q   <= '0;
			rate_smooth_q <= '0;
			min_frac_q    <= '0;
			clock_q       <= '0;
			out_valid     <= 1'b0;
			wait_div_q    <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == frmc_pkg::REG_TARGET) begin
					target_q <= pwdata[9:0];
				end else begin
					pause_q <= pwdata[0];
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						raw_q   <= raw_dt_us;
						delta_q <= '0;
						upd_q   <= 1'b0;
						sleep_q <= '0;
						if (cmd == frmc_pkg::CMD_LOAD) begin
							clock_q    <= time_word;
							min_frac_q <= '0;
							state_q    <= ST_OUT;
						end else if (first_q) begin
							first_q <= 1'b0;
							state_q <= ST_OUT;
						end else if (pause_q) begin
							state_q <= ST_OUT;
						end else begin
							delta_q <= (raw_dt_us > 24'(frmc_pkg::MAX_DELTA_US))
								? frmc_pkg::MAX_DELTA_US : raw_dt_us[17:0];
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					elapsed_q    <= elapsed_q + 48'(delta_q);
					frames_q     <= frames_q + 32'd1;
					win_time_q   <= win_sum;
					win_frames_q <= wf_inc;
					if (frac_sum >= 27'(frmc_pkg::MINUTE_US)) begin
						min_frac_q <= 26'(frac_sum - 27'(frmc_pkg::MINUTE_US));
						clock_q    <= {clock_q[31:11], hr1, mn1};
					end else begin
						min_frac_q <= frac_sum[25:0];
					end
					state_q <= ST_SLEEP;
				end
				ST_SLEEP: begin
					if (target_q == 10'd0 || load >= 35'd1000000 ||
					    (35'd1000000 - load) <= 35'(target_q) * 35'd1000) begin
						state_q <= ST_RATE;
					end else if (!wait_div_q) begin
						wait_div_q <= 1'b1;
					end else if (div_done) begin
						wait_div_q <= 1'b0;
						sleep_q    <= div_quot[19:0];
						state_q    <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (win_time_q < frmc_pkg::WINDOW_US) begin
						state_q <= ST_OUT;
					end else if (!wait_div_q) begin
						wait_div_q <= 1'b1;
					end else if (div_done) begin
						wait_div_q  <= 1'b0;
						rate_last_q <= (div_quot > frmc_pkg::DW'(frmc_pkg::MASK28))
							? frmc_pkg::MASK28 : div_quot[27:0];
						upd_q       <= 1'b1;
						state_q     <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (rate_smooth_q == 28'd0) begin
						rate_smooth_q <= rate_last_q;
						win_time_q    <= '0;
						win_frames_q  <= '0;
						state_q       <= ST_OUT;
					end else if (!wait_div_q) begin
						wait_div_q <= 1'b1;
					end else if (div_done) begin
						wait_div_q    <= 1'b0;
						rate_smooth_q <= div_quot[27:0];
						win_time_q    <= '0;
						win_frames_q  <= '0;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					delta_us      <= delta_q;
					elapsed_us    <= elapsed_q;
					frames_total  <= frames_q;
					rate_now      <= rate_last_q;
					rate_avg      <= rate_smooth_q;
					rate_updated  <= upd_q;
					clock_hour    <= clock_q[10:6];
					clock_minute  <= clock_q[5:0];
					minute_of_day <= 11'(clock_q[10:6] * 11'd60) + 11'(clock_q[5:0]);
					sleep_us      <= sleep_q;
					clock_word    <= clock_q;
					out_valid     <= 1'b1;
					state_q       <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/frmc_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for 50-bit dividends and
// 32-bit divisors.
// ----------------------------------------------------------------------------
module frmc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [frmc_pkg::DW-1:0]  dividend,
	input  logic [31:0]              divisor,
	output logic                     done,
	output logic [frmc_pkg::DW-1:0]  quotient
);

	logic [frmc_pkg::DW-1:0] q_q;
	logic [32:0]             rem_q;
	logic [31:0]             dvs_q;
	logic [5:0]              cnt_q;
	logic                    busy_q;
	logic [32:0]             trial;
	logic [33:0]             diff;

	assign trial = {rem_q[31:0], q_q[frmc_pkg::DW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(frmc_pkg::DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				q_q   <= {q_q[frmc_pkg::DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[frmc_pkg::DW-2:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;

endmodule

// File: tb/sv/frame_meter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame rate meter checker
// Watches the item channels and the register writes, keeps its own copy of
// the meter state, and compares every result item field by field.
// ----------------------------------------------------------------------------
module frame_meter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [23:0] raw_dt_us,
	input  logic [31:0] time_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [17:0] delta_us,
	input  logic [47:0] elapsed_us,
	input  logic [31:0] frames_total,
	input  logic [27:0] rate_now,
	input  logic [27:0] rate_avg,
	input  logic        rate_updated,
	input  logic [4:0]  clock_hour,
	input  logic [5:0]  clock_minute,
	input  logic [10:0] minute_of_day,
	input  logic [19:0] sleep_us,
	input  logic [31:0] clock_word,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [17:0] delta;
		logic [47:0] elapsed;
		logic [31:0] frames;
		logic [27:0] rnow;
		logic [27:0] ravg;
		logic        upd;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [10:0] mod;
		logic [19:0] sleep;
		logic [31:0] word;
	} meter_result_t;

	meter_result_t meter_expected[$];

	logic [9:0]  target_q;
	logic        pause_q;
	logic        armed_wait;
	logic [47:0] elapsed_q;
	logic [31:0] frames_q;
	logic [20:0] win_time_q;
	logic [19:0] win_frames_q;
	logic [27:0] rate_last_q;
	logic [27:0] rate_smooth_q;
	logic [25:0] minute_frac_q;
	logic [31:0] clock_q;

	assign pending_count = meter_expected.size();

	function automatic logic [31:0] next_minute(input logic [31:0] w);
		logic [6:0] m;
		logic [5:0] h;
		m = {1'b0, w[5:0]} + 7'd1;
		h = {1'b0, w[10:6]};
		if (m >= 7'd60) begin
			m = 0;
			h = h + 6'd1;
			if (h >= 6'd24)
				h = 0;
		end
		return {w[31:11], h[4:0], m[5:0]};
	endfunction

	function automatic logic [19:0] sleep_hint(input logic [23:0] raw);
		logic [63:0] t, load;
		t = {54'd0, target_q};
		if (t == 0)
			return 0;
		load = raw * t;
		if (load >= 64'd1000000)
			return 0;
		if (64'd1000000 - load <= 64'd1000 * t)
			return 0;
		return 20'((64'd1000000 - load) / t);
	endfunction

	task automatic predict_item(input logic c, input logic [23:0] raw, input logic [31:0] w);
		meter_result_t r;
		logic [63:0] q;
		logic [31:0] mf;
		r = '0;
		if (c == frmc_pkg::CMD_LOAD) begin
			clock_q = w;
			minute_frac_q = 0;
		end else if (armed_wait) begin
			armed_wait = 0;
		end else if (!pause_q) begin
			r.delta = (raw > 24'(frmc_pkg::MAX_DELTA_US)) ? frmc_pkg::MAX_DELTA_US : raw[17:0];
			elapsed_q = elapsed_q + 48'(r.delta);
			frames_q = frames_q + 1;
			win_time_q = win_time_q + 21'(r.delta);
			if (win_frames_q < frmc_pkg::FRAMES_MAX)
				win_frames_q = win_frames_q + 1;
			if (win_time_q >= frmc_pkg::WINDOW_US) begin
				q = (64'(win_frames_q) * 64'd256000000) / 64'(win_time_q);
				rate_last_q = (q > 64'(frmc_pkg::MASK28)) ? frmc_pkg::MASK28 : q[27:0];
				if (rate_smooth_q == 0)
					rate_smooth_q = rate_last_q;
				else
					rate_smooth_q = 28'((64'(rate_smooth_q) * 9 + 64'(rate_last_q)) / 10);
				win_time_q = 0;
				win_frames_q = 0;
				r.upd = 1;
			end
			mf = 32'(minute_frac_q) + 32'(r.delta);
			if (mf >= 32'(frmc_pkg::MINUTE_US)) begin
				mf = mf - 32'(frmc_pkg::MINUTE_US);
				clock_q = next_minute(clock_q);
			end
			minute_frac_q = mf[25:0];
			r.sleep = sleep_hint(raw);
		end
		r.elapsed = elapsed_q;
		r.frames = frames_q;
		r.rnow = rate_last_q;
		r.ravg = rate_smooth_q;
		r.hour = clock_q[10:6];
		r.minute = clock_q[5:0];
		r.mod = 11'(clock_q[10:6] * 60 + clock_q[5:0]);
		r.word = clock_q;
		meter_expected.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0d, actual %0d", name, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		meter_result_t e;
		if (!arst_n) begin
			fail_count <= 0;
			meter_expected.delete();
			target_q = 10'd60;
			pause_q = 0;
			armed_wait = 1;
			elapsed_q = 0;
			frames_q = 0;
			win_time_q = 0;
			win_frames_q = 0;
			rate_last_q = 0;
			rate_smooth_q = 0;
			minute_frac_q = 0;
			clock_q = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == frmc_pkg::REG_PAUSE)
					pause_q = pwdata[0];
				else
					target_q = pwdata[9:0];
			end
			if (in_valid && !in_stall)
				predict_item(cmd, raw_dt_us, time_word);
			if (out_valid && !out_stall) begin
				if (meter_expected.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					e = meter_expected.pop_front();
					check_field("delta_us", e.delta, delta_us);
					check_field("elapsed_us", e.elapsed, elapsed_us);
					check_field("frames_total", e.frames, frames_total);
					check_field("rate_now", e.rnow, rate_now);
					check_field("rate_avg", e.ravg, rate_avg);
					check_field("rate_updated", e.upd, rate_updated);
					check_field("clock_hour", e.hour, clock_hour);
					check_field("clock_minute", e.minute, clock_minute);
					check_field("minute_of_day", e.mod, minute_of_day);
					check_field("sleep_us", e.sleep, sleep_us);
					check_field("clock_word", e.word, clock_word);
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame rate meter testbench
// Drives directed and random tick and set-time items under several register
// settings and idling patterns; the checker compares every result item.
// ----------------------------------------------------------------------------
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic        cmd;
	logic [23:0] raw_dt_us;
	logic [31:0] time_word;
	logic        out_valid, out_stall;
	logic [17:0] delta_us;
	logic [47:0] elapsed_us;
	logic [31:0] frames_total;
	logic [27:0] rate_now, rate_avg;
	logic        rate_updated;
	logic [4:0]  clock_hour;
	logic [5:0]  clock_minute;
	logic [10:0] minute_of_day;
	logic [19:0] sleep_us;
	logic [31:0] clock_word;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	frame_rate_meter_with_game_clock DUT (.*);
	frame_meter_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
			out_stall <= 1;
		else
			out_stall <= 0;
	end

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic c, input logic [23:0] raw, input logic [31:0] w);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		raw_dt_us <= raw;
		time_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_items(input int n);
		int k;
		logic [23:0] raw;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: raw = $urandom;
				1: raw = $urandom_range(250000, 16777215);
				2, 3: raw = $urandom_range(1000);
				default: raw = $urandom_range(40000);
			endcase
			if ($urandom_range(19) == 0)
				send_item(frmc_pkg::CMD_LOAD, $urandom, $urandom);
			else
				send_item(frmc_pkg::CMD_TICK, raw, $urandom);
		end
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; cmd = 0; raw_dt_us = 0; time_word = 0; out_stall = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(frmc_pkg::REG_PAUSE, 1);
		send_item(frmc_pkg::CMD_TICK, 24'd500, 0);
		send_item(frmc_pkg::CMD_TICK, 24'd500, 0);
		drain();
		write_reg(frmc_pkg::REG_PAUSE, 0);
		write_reg(frmc_pkg::REG_TARGET, 1000);
		send_item(frmc_pkg::CMD_LOAD, 0, 32'hFFFF_F7FF);
		send_item(frmc_pkg::CMD_TICK, 24'hFFFFFF, 0);
		send_item(frmc_pkg::CMD_TICK, 0, 0);
		send_item(frmc_pkg::CMD_TICK, 24'd249999, 0);
		send_item(frmc_pkg::CMD_TICK, 24'd250000, 0);
		send_item(frmc_pkg::CMD_TICK, 24'd250001, 0);
		send_item(frmc_pkg::CMD_LOAD, 0, 32'h0000_05FB);
		repeat (8) send_item(frmc_pkg::CMD_TICK, 24'hFFFFFF, 0);
		send_item(frmc_pkg::CMD_LOAD, 0, 32'h0000_07FF);
		repeat (4) send_item(frmc_pkg::CMD_TICK, 24'd1, 0);
		send_item(frmc_pkg::CMD_LOAD, 0, 32'h0);
		drain();
		write_reg(frmc_pkg::REG_TARGET, 0);
		send_idle_pct = 26; recv_idle_pct = 79;
		random_items(600);
		drain();
		write_reg(frmc_pkg::REG_TARGET, 60);
		write_reg(frmc_pkg::REG_PAUSE, 1);
		random_items(60);
		drain();
		write_reg(frmc_pkg::REG_PAUSE, 0);
		send_idle_pct = 79; recv_idle_pct = 26;
		random_items(600);
		drain();
		write_reg(frmc_pkg::REG_TARGET, $urandom_range(1, 999));
		send_idle_pct = 0; recv_idle_pct = 0;
		random_items(600);
		drain();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
